// File: design/scn_pkg.sv
// Shared types and constants for the star catalog narrower.
// Used by every module of the block; depends on nothing.
package scn_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int XW   = 16;
  localparam int MAGW = 12;
  localparam int IDW  = 15;
  localparam int MSW  = 7;
  localparam int THRW = 32;

  // register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_MAX_MAG   = 2'd0;
  localparam logic [1:0] REG_MAX_STARS = 2'd1;
  localparam logic [1:0] REG_COS_THR   = 2'd2;

  localparam logic signed [MAGW-1:0] MAX_MAG_RST   = 12'sd2047;
  localparam logic [MSW-1:0]         MAX_STARS_RST = 7'd64;
  localparam logic signed [THRW-1:0] COS_THR_RST   = 32'sd1073741824;

  // one stored star plus its removal mark
  typedef struct packed {
    logic signed [XW-1:0]   x;
    logic signed [XW-1:0]   y;
    logic signed [XW-1:0]   z;
    logic signed [MAGW-1:0] mag;
    logic [IDW-1:0]         id;
    logic                   mark;
  } star_t;

endpackage

// File: design/scn_cell.sv
// One cell of the star ring: holds one star and passes it to its neighbor.
// Depends on scn_pkg.
module scn_cell (
  input  logic          clk,
  input  logic          shift,
  input  scn_pkg::star_t in_star,
  input  logic          load,
  input  scn_pkg::star_t load_star,
  output scn_pkg::star_t cur
);
  import scn_pkg::*;

  // load a new star or take the neighbor's star on rotation
  always_ff @(posedge clk) begin
    if (load) begin
      cur <= load_star;
    end else if (shift) begin
      cur <= in_star;
    end
  end

endmodule

// File: design/scn_dot.sv
// Dot product of two Q1.15 vectors against a Q2.30 threshold: registered products,
// then a combinational add and compare. Depends on scn_pkg.
module scn_dot (
  input  logic                            clk,
  input  scn_pkg::star_t                  probe,
  input  scn_pkg::star_t                  head,
  input  logic signed [scn_pkg::THRW-1:0] thr,
  output logic                            close
);
  import scn_pkg::*;

  logic signed [2*XW-1:0] px, py, pz;
  logic signed [2*XW+1:0] sum;

  // register the three products
  always_ff @(posedge clk) begin
    px <= probe.x * head.x;
    py <= probe.y * head.y;
    pz <= probe.z * head.z;
  end

  // add and compare
  assign sum   = (2*XW+2)'(px) + (2*XW+2)'(py) + (2*XW+2)'(pz);
  assign close = sum > (2*XW+2)'(thr);

endmodule

// File: design/star_catalog_narrower_core.sv
// Star catalog narrower top level: ring of star cells, dot unit, sequencer.
// Depends on scn_pkg, scn_cell and scn_dot.
//
// Stars load one per cycle into a ring of CAPACITY cells while the sequencer
// is in its load state. After the star with tlast, the ring rotates one full turn
// per stored star to test every pair with the single dot unit, holding each
// compared position while its registered products settle; one turn counts the
// survivors, and then each emitted star takes two turns: one to find the
// brightest remaining (or next in load order) and one to fetch it. The run
// also stretches on output stalls.
// No input is accepted during that run.
module star_catalog_narrower_core #(
  parameter int CAPACITY = scn_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // star input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,  // vec_x, vec_y, vec_z, star_magnitude, star_id
  input  logic        s_tlast,  // final_star
  // result output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,  // out_x, out_y, out_z, out_magnitude, out_id
  output logic        m_tlast,  // list_end
  output logic [1:0]  m_tuser   // list_empty, overflowed
);
  import scn_pkg::*;

  localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [6:0] {
    ST_LOAD   = 7'b0000001,
    ST_CLOSE  = 7'b0000010,
    ST_COUNT  = 7'b0000100,
    ST_DECIDE = 7'b0001000,
    ST_FIND   = 7'b0010000,
    ST_FETCH  = 7'b0100000,
    ST_EMPTY  = 7'b1000000
  } state_t;

  state_t state;

  logic signed [MAGW-1:0] max_magnitude;
  logic [MSW-1:0]         max_stars;
  logic signed [THRW-1:0] cos_threshold;

  logic [CW-1:0] count, circ, surv, remain;
  logic [PW-1:0] pos, wb_pos, best_pos;
  logic          ovf, sub, probe_mark, wb_valid, found, sort;
  logic signed [MAGW-1:0] best_mag;
  star_t         probe;

  star_t cells [CAPACITY];
  star_t head_next, in_star;
  logic  rot, set_mark, load_en, close, pos_last, in_range, cand, out_free, emit;
  logic  in_acc, keep_star;

  // APB register file
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      max_magnitude <= MAX_MAG_RST;
      max_stars     <= MAX_STARS_RST;
      cos_threshold <= COS_THR_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_MAX_MAG:   max_magnitude <= pwdata[MAGW-1:0];
        REG_MAX_STARS: max_stars     <= pwdata[MSW-1:0];
        REG_COS_THR:   cos_threshold <= pwdata[THRW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MAX_MAG:   prdata = 32'(max_magnitude);
      REG_MAX_STARS: prdata = 32'(max_stars);
      REG_COS_THR:   prdata = cos_threshold;
      default:       prdata = 32'd0;
    endcase
  end

  // unpack the input transaction
  always_comb begin
    in_star.x    = s_tdata[15:0];
    in_star.y    = s_tdata[31:16];
    in_star.z    = s_tdata[47:32];
    in_star.mag  = s_tdata[59:48];
    in_star.id   = s_tdata[74:60];
    in_star.mark = 1'b0;
  end

  assign s_tready  = (state == ST_LOAD);
  assign in_acc    = s_tvalid && s_tready;
  assign keep_star = $signed(in_star.mag) <= max_magnitude;
  assign load_en   = in_acc && keep_star && (count < CW'(CAPACITY));

  // ring of cells; the head feeds the tail with its mark updated
  assign head_next = '{x: cells[0].x, y: cells[0].y, z: cells[0].z, mag: cells[0].mag,
                       id: cells[0].id, mark: cells[0].mark | set_mark};

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    scn_cell u_cell (
      .clk      (clk),
      .shift    (rot),
      .in_star  ((k == CAPACITY - 1) ? head_next : cells[(k + 1) % CAPACITY]),
      .load     (load_en && (count == CW'(k))),
      .load_star(in_star),
      .cur      (cells[k])
    );
  end

  scn_dot u_dot (
    .clk  (clk),
    .probe(probe),
    .head (cells[0]),
    .thr  (cos_threshold),
    .close(close)
  );

  assign pos_last = (pos == PW'(CAPACITY - 1));
  assign in_range = (CW'(pos) > circ) && (CW'(pos) < count);
  assign cand     = (CW'(pos) < count) && !cells[0].mark;
  assign out_free = !m_tvalid || m_tready;

  // rotation and marking for the current phase
  always_comb begin
    rot      = 1'b0;
    set_mark = 1'b0;
    emit     = 1'b0;
    case (state)
      ST_CLOSE: begin
        if (circ != count && !(in_range && !sub)) begin
          rot      = 1'b1;
          set_mark = (in_range && close) || (wb_valid && pos == wb_pos);
        end
      end
      ST_COUNT, ST_FIND: rot = 1'b1;
      ST_FETCH: begin
        if (pos == best_pos) begin
          emit     = out_free;
          rot      = out_free;
          set_mark = out_free;
        end else begin
          rot = 1'b1;
        end
      end
      ST_EMPTY: emit = out_free;
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      ovf      <= 1'b0;
      pos      <= '0;
      circ     <= '0;
      sub      <= 1'b0;
      wb_valid <= 1'b0;
      found    <= 1'b0;
    end else begin
      if (rot) begin
        pos <= pos_last ? '0 : pos + PW'(1);
      end
      case (state)
        ST_LOAD: begin
          if (in_acc) begin
            if (load_en) begin
              count <= count + CW'(1);
            end else if (keep_star) begin
              ovf <= 1'b1;
            end
            if (s_tlast) begin
              state    <= ST_CLOSE;
              circ     <= '0;
              sub      <= 1'b0;
              wb_valid <= 1'b0;
            end
          end
        end
        ST_CLOSE: begin
          if (circ == count) begin
            state <= ST_COUNT;
            surv  <= '0;
          end else begin
            if (CW'(pos) == circ) begin
              probe      <= cells[0];
              probe_mark <= 1'b0;
            end
            if (in_range && !sub) begin
              sub <= 1'b1;
            end else begin
              sub <= 1'b0;
              if (in_range && close) begin
                probe_mark <= 1'b1;
              end
              if (pos_last) begin
                circ     <= circ + CW'(1);
                wb_valid <= probe_mark || (in_range && close);
                wb_pos   <= circ[PW-1:0];
              end
            end
          end
        end
        ST_COUNT: begin
          if (cand) begin
            surv <= surv + CW'(1);
          end
          if (pos_last) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          sort   <= 8'(surv) > 8'(max_stars);
          remain <= (8'(surv) > 8'(max_stars)) ? CW'(max_stars) : surv;
          found  <= 1'b0;
          if (surv == '0 || max_stars == '0) begin
            state <= ST_EMPTY;
          end else begin
            state <= ST_FIND;
          end
        end
        ST_FIND: begin
          if (cand && (!found || (sort && cells[0].mag < best_mag))) begin
            found    <= 1'b1;
            best_pos <= pos;
            best_mag <= cells[0].mag;
          end
          if (pos_last) begin
            state <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          if (rot && pos_last) begin
            found <= 1'b0;
            if (remain == CW'(1)) begin
              state <= ST_LOAD;
              count <= '0;
              ovf   <= 1'b0;
            end else begin
              remain <= remain - CW'(1);
              state  <= ST_FIND;
            end
          end
        end
        ST_EMPTY: begin
          if (out_free) begin
            state <= ST_LOAD;
            count <= '0;
            ovf   <= 1'b0;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  // output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (state == ST_EMPTY) begin
        m_tdata <= '0;
        m_tlast <= 1'b1;
        m_tuser <= {ovf, 1'b1};
      end else begin
        m_tdata <= {5'd0, cells[0].id, cells[0].mag, cells[0].z, cells[0].y, cells[0].x};
        m_tlast <= (remain == CW'(1));
        m_tuser <= {ovf, 1'b0};
      end
    end
  end

  // checks
  a_count_cap: assert property (@(posedge clk) disable iff (rst) count <= CW'(CAPACITY))
    else $error("star count above capacity");
  a_empty_end: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && m_tuser[0] |-> m_tlast)
    else $error("empty list result without list end");
  a_remain: assert property (@(posedge clk) disable iff (rst)
      (state == ST_FIND || state == ST_FETCH) |-> remain != '0)
    else $error("selection running with nothing left to emit");

endmodule

// File: tb/sv/star_catalog_narrower_core_tb.sv
// Testbench for star_catalog_narrower_core: star loads, proximity filter, top-k.
// Depends on scn_pkg and the block's RTL; predicts every list in-line.
`timescale 1ns / 100ps

module star_catalog_narrower_core_tb;
  import scn_pkg::*;

  localparam int CAP = 64;
  localparam int WATCHDOG_LIMIT = 2000000;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic signed [11:0] mag;
    logic [14:0]        id;
    logic               last;
    logic               empty;
    logic               ovf;
  } star_rec_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic        m_tlast;
  logic [1:0]  m_tuser;

  star_catalog_narrower_core DUT (.*);

  always #5 clk = ~clk;

  // predictor state
  logic signed [11:0] mag_limit = MAX_MAG_RST;
  logic [6:0]         star_limit = MAX_STARS_RST;
  logic signed [31:0] close_thr = COS_THR_RST;
  logic signed [15:0] sx [CAP], sy [CAP], sz [CAP];
  logic signed [11:0] smag [CAP];
  logic [14:0]        sid [CAP];
  int                 stored = 0;
  bit                 dropped_full = 0;
  star_rec_t          pending_stars [$];

  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  timed_out = 0;
  bit  out_idle_on = 1;

  function automatic int rand_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
  endfunction

  // Append one star, and on the final one produce the predicted list.
  task automatic predict_star(input logic signed [15:0] x, y, z,
                              input logic signed [11:0] m, input logic [14:0] id,
                              input bit fin);
    bit          near [CAP];
    int          order [CAP];
    int          n, keep, v, j;
    longint      d;
    star_rec_t   r;
    n = 0;
    if (m <= mag_limit) begin
      if (stored < CAP) begin
        sx[stored] = x; sy[stored] = y; sz[stored] = z;
        smag[stored] = m; sid[stored] = id;
        stored++;
      end else begin
        dropped_full = 1;
      end
    end
    if (!fin) return;
    for (int i = 0; i < CAP; i++) near[i] = 0;
    for (int i = 0; i < stored; i++)
      for (int k = i + 1; k < stored; k++) begin
        d = longint'(sx[i]) * sx[k] + longint'(sy[i]) * sy[k] + longint'(sz[i]) * sz[k];
        if (d > longint'(close_thr)) begin
          near[i] = 1; near[k] = 1;
        end
      end
    for (int i = 0; i < stored; i++)
      if (!near[i]) order[n++] = i;
    keep = n;
    if (n > star_limit) begin
      for (int i = 1; i < n; i++) begin
        v = order[i];
        j = i;
        while (j > 0 && smag[order[j-1]] > smag[v]) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = v;
      end
      keep = star_limit;
    end
    if (keep == 0) begin
      r = '0; r.last = 1; r.empty = 1; r.ovf = dropped_full;
      pending_stars = {pending_stars, r};
    end else begin
      for (int i = 0; i < keep; i++) begin
        r.x = sx[order[i]]; r.y = sy[order[i]]; r.z = sz[order[i]];
        r.mag = smag[order[i]]; r.id = sid[order[i]];
        r.last = (i == keep - 1); r.empty = 0; r.ovf = dropped_full;
        pending_stars = {pending_stars, r};
      end
    end
    stored = 0;
    dropped_full = 0;
  endtask

  // Send one star and wait for its transaction; valid drops only over a gap.
  task automatic send_star(input logic signed [15:0] x, y, z,
                           input logic signed [11:0] m, input logic [14:0] id,
                           input bit fin);
    int gap;
    gap = rand_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, id, m, z, y, x};
    s_tlast  <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_star(x, y, z, m, id, fin);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_MAX_MAG:   mag_limit = val[11:0];
      REG_MAX_STARS: star_limit = val[6:0];
      REG_COS_THR:   close_thr = val;
      default: ;
    endcase
  endtask

  // Drop the input and drain outstanding results before touching registers.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_stars.size() != 0 && !timed_out) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic configure(input int mmag, input int mstars, input int thr);
    wait_drained();
    write_reg(REG_MAX_MAG, 32'(mmag));
    write_reg(REG_MAX_STARS, 32'(mstars));
    write_reg(REG_COS_THR, 32'(thr));
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Random star: vectors mostly spread, sometimes clustered near a shared axis.
  task automatic send_random_star(input bit fin, input bit clustered);
    logic signed [15:0] x, y, z;
    x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
    if (clustered) begin
      x = 16'sd30000 + $signed(16'($urandom_range(0, 400)));
      y = 16'($urandom_range(0, 300));
      z = 16'($urandom_range(0, 300));
    end
    send_star(x, y, z, 12'($urandom), 15'($urandom), fin);
  endtask

  task automatic test_directed();
    configure(2047, 64, 32'sh4000_0000);
    send_star(16'sh7fff, 0, 0, 12'sh7ff, 15'h7fff, 0);
    send_star(16'sh8000, 16'sh7fff, 16'sh8000, 12'sh800, 0, 0);
    send_star(0, 16'sh8000, 16'sh7fff, 0, 15'h1234, 1);
    // all stars too faint: empty list
    configure(-2048, 64, 32'sh4000_0000);
    send_star(1, 2, 3, 12'sh7ff, 5, 0);
    send_star(1, 2, 3, 12'sh801, 6, 1);
    // every pair close, all three stars removed, negative threshold
    configure(2047, 64, -32'sh4000_0000);
    send_star(16'sh4000, 0, 0, 10, 1, 0);
    send_star(16'sh4000, 0, 0, 20, 2, 0);
    send_star(16'shc000, 0, 0, 30, 3, 1);
    // limit of zero
    configure(2047, 0, 32'sh4000_0000);
    send_star(5, 5, 5, 100, 9, 0);
    send_star(-5, 5, 5, 100, 10, 1);
    // ranking with ties, limit two
    configure(2047, 2, 32'sh4000_0000);
    send_star(1, 0, 0, 50, 11, 0);
    send_star(0, 1, 0, -7, 12, 0);
    send_star(0, 0, 1, 50, 13, 0);
    send_star(1, 1, 0, -7, 14, 1);
  endtask

  task automatic test_overflow();
    configure(2047, 64, 32'sh4000_0000);
    for (int i = 0; i < CAP + 3; i++)
      send_star(16'(i), 16'(i * 3), 16'(-i), 12'(i), 15'(i), i == CAP + 2);
    configure(2047, 10, 32'sh4000_0000);
    for (int i = 0; i < CAP + 1; i++)
      send_star(16'(i), 16'(7), 16'(i), 12'($urandom), 15'(i), i == CAP);
  endtask

  task automatic test_random();
    int sent, len;
    bit cl;
    sent = 0;
    while (sent < 300 && !timed_out) begin
      configure($urandom_range(0, 4) == 0 ? $urandom_range(0, 4095) - 2048 : 2047,
                $urandom_range(0, 4) == 0 ? $urandom_range(0, 64) : $urandom_range(1, 8),
                $urandom_range(0, 3) == 0 ? 32'sh4000_0000 :
                  ($urandom_range(0, 3) == 0 ? -32'sh4000_0000 :
                   int'($urandom_range(0, 2000000000)) - 1000000000 + 32'sh1000_0000));
      out_idle_on = $urandom_range(0, 3) != 0;
      len = $urandom_range(1, 14);
      cl = $urandom_range(0, 2) == 0;
      for (int i = 0; i < len; i++)
        send_random_star(i == len - 1, cl && $urandom_range(0, 1));
      sent += len;
    end
    out_idle_on = 1;
  endtask

  // Output ready with random stalls.
  initial begin
    int stall;
    m_tready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      stall = 0;
      if (out_idle_on && $urandom_range(0, 2) == 0) stall = rand_gap();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    star_rec_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[59:48],
             m_tdata[74:60], m_tlast, m_tuser[0], m_tuser[1]};
      if (pending_stars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_stars.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %h actual %h", want, got);
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_random();
    wait_drained();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_stars.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: files.f
design/scn_pkg.sv
design/scn_cell.sv
design/scn_dot.sv
design/star_catalog_narrower_core.sv
tb/sv/star_catalog_narrower_core_tb.sv
